/* design/imuopc_pkg.sv */
// Shared types and constants for the inertial sensor offset calibrator.
package imuopc_pkg;

  // Fixed field widths of the sample and result beats.
  localparam int unsigned NumAxes   = 6;
  localparam int unsigned SampleW   = 16;
  localparam int unsigned OffsetW   = 18;
  localparam int unsigned IntegW    = 48;
  localparam int unsigned RoundsW   = 8;
  localparam int unsigned GravityW  = 15;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 15;
  localparam int unsigned InTdataW  = NumAxes * SampleW;
  localparam int unsigned OutTdataW = ((NumAxes * OffsetW + 7) / 8) * 8;

  // Axis order inside the beat: accelerometer X, Y, Z, then gyro X, Y, Z.
  localparam int unsigned AxisAccelZ = 2;
  localparam int unsigned NumAccel   = 3;

  // Defaults for the top-level parameters.
  localparam int unsigned DefaultSamplesPerRound = 100;
  localparam int unsigned DefaultGainFracBits    = 24;

  // Register reset values.
  localparam logic [RoundsW-1:0]  RoundsReset  = RoundsW'(10);
  localparam logic [GravityW-1:0] GravityReset = GravityW'(16384);

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CfgRounds  = 1'b0,
    CfgGravity = 1'b1
  } cfg_idx_e;

  // Per-beat control handed from the sequencer to every axis loop.
  typedef struct packed {
    logic accept;     // a sample beat is taken this cycle
    logic clear;      // start request: offsets and integrals restart at zero
    logic update;     // the PI loops run on this sample
    logic round_end;  // this sample closes a round: integrals are cleared
  } imuopc_ctrl_t;

endpackage

/* design/imuopc_axis.sv */
// One axis PI loop: error, P term, saturating integral, rounded offset step.
module imuopc_axis
  import imuopc_pkg::*;
#(
  parameter int unsigned GAIN_FRAC_BITS = DefaultGainFracBits
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  imuopc_ctrl_t              ctrl_i,
  input  logic [GAIN_FRAC_BITS-1:0] kp_i,
  input  logic [GAIN_FRAC_BITS-1:0] ki_i,
  input  logic signed [SampleW-1:0] expect_i,
  input  logic signed [SampleW-1:0] reading_i,
  output logic signed [OffsetW-1:0] offset_o
);

  // Error range is below 2^18 in magnitude; one spare bit.
  localparam int unsigned EW = OffsetW + 2;
  localparam int unsigned PW = EW + GAIN_FRAC_BITS + 1;
  localparam int unsigned SW = ((PW > IntegW) ? PW : IntegW) + 1;
  localparam int unsigned AW = SW + 1;
  localparam int unsigned OW = AW + 1;

  localparam logic signed [SW-1:0] IntHi = SW'((longint'(1) << (IntegW - 1)) - 1);
  localparam logic signed [SW-1:0] IntLo = -IntHi - SW'(1);
  localparam logic [AW-1:0]        Half  = AW'(longint'(1) << (GAIN_FRAC_BITS + 1));
  localparam logic signed [OW-1:0] OffHi = OW'((longint'(1) << (OffsetW - 1)) - 1);
  localparam logic signed [OW-1:0] OffLo = -OffHi - OW'(1);

  logic signed [OffsetW-1:0] offset_q, offset_d, off_cur;
  logic signed [IntegW-1:0]  integ_q, integ_d, int_cur, int_sat;
  logic signed [EW-1:0]      err;
  logic signed [PW-1:0]      prod_p, prod_i;
  logic signed [SW-1:0]      int_sum;
  logic signed [AW-1:0]      sum;
  logic [AW-1:0]             mag, q;
  logic                      neg;
  logic signed [OW-1:0]      off_wide;
  logic signed [OffsetW-1:0] off_new;

  // Loop arithmetic on the state as it stands after a possible restart.
  always_comb begin
    off_cur = ctrl_i.clear ? '0 : offset_q;
    int_cur = ctrl_i.clear ? '0 : integ_q;
    err     = EW'(expect_i) - EW'(reading_i) + EW'(off_cur);
    prod_p  = PW'(err) * PW'($signed({1'b0, kp_i}));
    prod_i  = PW'(err) * PW'($signed({1'b0, ki_i}));
    int_sum = SW'(int_cur) + SW'(prod_i);
    if (int_sum > IntHi) begin
      int_sat = IntegW'(IntHi);
    end else if (int_sum < IntLo) begin
      int_sat = IntegW'(IntLo);
    end else begin
      int_sat = IntegW'(int_sum);
    end
    sum = AW'(prod_p) + AW'(int_sat);
    neg = sum[AW-1];
    mag = neg ? AW'(-sum) : AW'(sum);
    q   = (mag + Half) >> (GAIN_FRAC_BITS + 2);
    // Step is subtracted from the offset, sign restored from the sum.
    off_wide = OW'(off_cur) + (neg ? $signed({1'b0, q}) : -$signed({1'b0, q}));
    if (off_wide > OffHi) begin
      off_new = OffsetW'(OffHi);
    end else if (off_wide < OffLo) begin
      off_new = OffsetW'(OffLo);
    end else begin
      off_new = OffsetW'(off_wide);
    end
  end

  // Next state for an accepted beat.
  always_comb begin
    offset_d = offset_q;
    integ_d  = integ_q;
    if (ctrl_i.accept) begin
      if (ctrl_i.update) begin
        offset_d = off_new;
        integ_d  = ctrl_i.round_end ? '0 : int_sat;
      end else if (ctrl_i.clear) begin
        offset_d = '0;
        integ_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
      integ_q  <= '0;
    end else begin
      offset_q <= offset_d;
      integ_q  <= integ_d;
    end
  end

  assign offset_o = ctrl_i.update ? off_new : off_cur;

endmodule

/* design/imuopc_ctrl.sv */
// Calibration sequencer: registers, gains, sample and round counters.
module imuopc_ctrl
  import imuopc_pkg::*;
#(
  parameter int unsigned SAMPLES_PER_ROUND = DefaultSamplesPerRound,
  parameter int unsigned GAIN_FRAC_BITS    = DefaultGainFracBits
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CfgIdxW-1:0]         cfg_idx_i,
  input  logic [CfgDataW-1:0]        cfg_wdata_i,
  input  logic                       accept_i,
  input  logic                       start_i,
  output imuopc_ctrl_t               ctrl_o,
  output logic [GAIN_FRAC_BITS-1:0]  kp_o,
  output logic [GAIN_FRAC_BITS-1:0]  ki_accel_o,
  output logic [GAIN_FRAC_BITS-1:0]  ki_gyro_o,
  output logic [GravityW-1:0]        gravity_o,
  output logic                       busy_o
);

  localparam int unsigned    GW  = GAIN_FRAC_BITS;
  localparam int unsigned    CW  = $clog2(SAMPLES_PER_ROUND + 1);
  localparam longint         One = longint'(1) << GAIN_FRAC_BITS;
  localparam logic [GW-1:0]  KpInit      = GW'((3 * One + 5) / 10);
  localparam logic [GW-1:0]  KiAccelInit = GW'((9 * One + 50) / 100);
  localparam logic [GW-1:0]  KiGyroInit  = GW'((2 * One + 50) / 100);
  localparam logic [CW-1:0]  SprLast     = CW'(SAMPLES_PER_ROUND);

  logic [RoundsW-1:0]  rounds_q;
  logic [GravityW-1:0] gravity_q;
  logic [GW-1:0]       kp_q, kp_d, kia_q, kia_d, kig_q, kig_d;
  logic [GW-1:0]       kp_cur, kia_cur, kig_cur;
  logic [CW-1:0]       cnt_q, cnt_d, cnt_cur, cnt_inc;
  logic [RoundsW-1:0]  rnd_q, rnd_d, rnd_cur, rnd_inc;
  logic                cal_q, cal_d, cal_cur, round_end;

  // Gain decay to three quarters, rounded down.
  function automatic logic [GW-1:0] decay(input logic [GW-1:0] g);
    logic [GW+1:0] t;
    t = {2'b00, g} + {1'b0, g, 1'b0};
    return GW'(t >> 2);
  endfunction

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rounds_q  <= RoundsReset;
      gravity_q <= GravityReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgRounds:  rounds_q  <= RoundsW'(cfg_wdata_i);
        CfgGravity: gravity_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // State as seen by this beat, after a possible restart.
  always_comb begin
    kp_cur    = start_i ? KpInit      : kp_q;
    kia_cur   = start_i ? KiAccelInit : kia_q;
    kig_cur   = start_i ? KiGyroInit  : kig_q;
    cnt_cur   = start_i ? '0 : cnt_q;
    rnd_cur   = start_i ? '0 : rnd_q;
    cal_cur   = start_i ? (rounds_q != '0) : cal_q;
    cnt_inc   = cnt_cur + CW'(1);
    rnd_inc   = rnd_cur + RoundsW'(1);
    round_end = cal_cur && (cnt_inc >= SprLast);
  end

  // Sequencer next state for an accepted beat.
  always_comb begin
    kp_d  = kp_q;
    kia_d = kia_q;
    kig_d = kig_q;
    cnt_d = cnt_q;
    rnd_d = rnd_q;
    cal_d = cal_q;
    if (accept_i) begin
      kp_d  = kp_cur;
      kia_d = kia_cur;
      kig_d = kig_cur;
      cnt_d = cnt_cur;
      rnd_d = rnd_cur;
      cal_d = cal_cur;
      if (cal_cur) begin
        cnt_d = cnt_inc;
        if (round_end) begin
          cnt_d = '0;
          kp_d  = decay(kp_cur);
          kia_d = decay(kia_cur);
          kig_d = decay(kig_cur);
          rnd_d = rnd_inc;
          cal_d = rnd_inc < rounds_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q  <= KpInit;
      kia_q <= KiAccelInit;
      kig_q <= KiGyroInit;
      cnt_q <= '0;
      rnd_q <= '0;
      cal_q <= 1'b0;
    end else begin
      kp_q  <= kp_d;
      kia_q <= kia_d;
      kig_q <= kig_d;
      cnt_q <= cnt_d;
      rnd_q <= rnd_d;
      cal_q <= cal_d;
    end
  end

  assign ctrl_o.accept    = accept_i;
  assign ctrl_o.clear     = start_i;
  assign ctrl_o.update    = cal_cur;
  assign ctrl_o.round_end = round_end;
  assign kp_o       = kp_cur;
  assign ki_accel_o = kia_cur;
  assign ki_gyro_o  = kig_cur;
  assign gravity_o  = gravity_q;
  assign busy_o     = cal_d;

endmodule

/* design/imu_offset_pi_calibrator_core.sv */
// Top level of the six-axis PI offset calibrator with stream ports.
// A result beat goes to the output register, or to the skid entry while the output waits.
// Throughput: one sample beat per cycle unless intake stalls; all six axis loops run in
// parallel and the offsets are fed back through one level of logic between state registers.
// A skid entry takes one more sample beat while a result waits; intake stalls when both are full.
// Reset (rst_ni low) clears offsets, integrals and counters, loads initial gains.
module imu_offset_pi_calibrator_core
  import imuopc_pkg::*;
#(
  parameter int unsigned SAMPLES_PER_ROUND = DefaultSamplesPerRound,
  parameter int unsigned GAIN_FRAC_BITS    = DefaultGainFracBits
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration write port.
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [CfgDataW-1:0]  cfg_wdata_i,
  // Sample beats.
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z (16 bits each)
  input  logic [InTdataW-1:0]  s_axis_tdata_i,
  // start_req
  input  logic                 s_axis_tuser_i,
  // Result beats.
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // offset_accel_x/y/z, offset_gyro_x/y/z (18 bits each), zero padding
  output logic [OutTdataW-1:0] m_axis_tdata_o,
  // busy_res
  output logic                 m_axis_tuser_o
);

  typedef struct packed {
    logic                           busy;
    logic [NumAxes*OffsetW-1:0]     offsets;
  } result_t;

  imuopc_ctrl_t               ctrl;
  logic [GAIN_FRAC_BITS-1:0]  kp, ki_accel, ki_gyro;
  logic [GravityW-1:0]        gravity;
  logic                       busy_next, accept;
  result_t                    res_new, out_q, skid_q;
  logic                       out_valid_q, skid_valid_q;

  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  imuopc_ctrl #(
    .SAMPLES_PER_ROUND(SAMPLES_PER_ROUND),
    .GAIN_FRAC_BITS   (GAIN_FRAC_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .accept_i   (accept),
    .start_i    (s_axis_tuser_i),
    .ctrl_o     (ctrl),
    .kp_o       (kp),
    .ki_accel_o (ki_accel),
    .ki_gyro_o  (ki_gyro),
    .gravity_o  (gravity),
    .busy_o     (busy_next)
  );

  // One PI loop per axis; only the Z accelerometer expects a nonzero reading.
  for (genvar k = 0; k < NumAxes; k++) begin : g_axis
    logic signed [SampleW-1:0] expect_val;
    logic signed [OffsetW-1:0] offset;

    assign expect_val = (k == AxisAccelZ) ? $signed({1'b0, gravity}) : '0;

    imuopc_axis #(
      .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
    ) u_axis (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .kp_i     (kp),
      .ki_i     ((k < NumAccel) ? ki_accel : ki_gyro),
      .expect_i (expect_val),
      .reading_i($signed(s_axis_tdata_i[k*SampleW +: SampleW])),
      .offset_o (offset)
    );

    assign res_new.offsets[k*OffsetW +: OffsetW] = offset;
  end

  assign res_new.busy = busy_next;

  // Output register with a skid entry behind it.
  assign s_axis_tready_o = !skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (m_axis_tready_i || !out_valid_q) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= accept;
      end
    end else if (accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (m_axis_tready_i || !out_valid_q) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (accept) begin
        out_q <= res_new;
      end
    end else if (accept) begin
      skid_q <= res_new;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OutTdataW'(out_q.offsets);
  assign m_axis_tuser_o  = out_q.busy;

endmodule
